// ----- rtl/core/wd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wd_pkg
// Shared types and constants of the waveform decimator.
// ----------------------------------------------------------------------------
package wd_pkg;

    localparam int MAX_SRC     = 4096;
    localparam int MAX_DST     = 1024;
    localparam int SAMPLE_BITS = 12;
    localparam int SRC_W       = 13;
    localparam int DST_W       = 11;
    localparam int IDX_W       = 10;
    localparam int SUM_W       = 24;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_MODE = 2'd2;

    localparam logic [1:0] MODE_MID  = 2'd0;
    localparam logic [1:0] MODE_AVG  = 2'd1;
    localparam logic [1:0] MODE_PEAK = 2'd2;

    typedef struct packed {
        logic                   mode;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] point_value;
        logic [IDX_W-1:0]       point_index;
        logic                   frame_end;
    } t_out_item;

    typedef struct packed {
        logic step;
        logic div_cfg;
        logic div_avg;
        logic load_qr;
        logic load_direct;
        logic load_div;
        logic load_pend;
    } t_dp_cmd;

    typedef struct packed {
        logic cfg_write;
        logic out_free;
        logic emit;
        logic close;
        logic two;
        logic avg;
        logic div_busy;
    } t_dp_status;

endpackage
`default_nettype wire

// ----- rtl/core/wd_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wd_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wd_divider #(
    parameter int DIVIDEND_W = wd_pkg::SUM_W,
    parameter int DIVISOR_W  = wd_pkg::SRC_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output      logic                  o_busy,
    output      logic [DIVIDEND_W-1:0] o_quotient,
    output      logic [DIVISOR_W-1:0]  o_remainder
);
    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_rem, n_rem, r_dvs;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic [DIVISOR_W:0]    shifted, diff;
    logic                  ge;

    always_comb begin
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        ge      = shifted >= {1'b0, r_dvs};
        diff    = shifted - {1'b0, r_dvs};
        n_rem   = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        n_quo   = {r_quo[DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIVIDEND_W);
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CW'(1);
            r_busy <= r_cnt != CW'(1);
            r_quo  <= n_quo;
            r_rem  <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule
`default_nettype wire

// ----- rtl/core/wd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wd_datapath
// Frame positions, bin accumulators, configuration and output register.
// ----------------------------------------------------------------------------
module wd_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [wd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [wd_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire wd_pkg::t_in_item             i_item,
    input  wire wd_pkg::t_dp_cmd              i_cmd,
    output      wd_pkg::t_dp_status           o_status,
    input  wire logic                         i_out_stall,
    output      logic                         o_out_valid,
    output      wd_pkg::t_out_item            o_out_data
);
    localparam int SB = wd_pkg::SAMPLE_BITS;
    localparam int SW = wd_pkg::SRC_W;
    localparam int DW = wd_pkg::DST_W;
    localparam int IW = wd_pkg::IDX_W;
    localparam int AW = SW - 1;
    localparam int RW = DW - 1;

    logic [SW-1:0] r_src;
    logic [DW-1:0] r_dst;
    logic [1:0]    r_mode;
    logic [AW-1:0] r_q;
    logic [RW-1:0] r_r;

    logic [SW-1:0] r_spos, n_spos;
    logic [DW-1:0] r_opos, n_opos;
    logic [AW-1:0] r_end, n_end, r_mid_pos, n_mid_pos;
    logic [RW-1:0] r_rem, n_rem;
    logic [wd_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [SW-1:0] r_cnt, n_cnt;
    logic [SB-1:0] r_min, n_min, r_max, n_max, r_mid_s, n_mid_s, r_last, n_last;
    logic [IW-1:0] r_avg_idx, n_avg_idx;
    wd_pkg::t_out_item r_pend, n_pend, r_out, direct;
    logic          r_out_valid;

    logic [SW-1:0] s_eff;
    logic [DW-1:0] d_eff;
    logic [AW-1:0] sm1, p, end_c, mid_c, qv;
    logic [RW-1:0] dm1, rv;
    logic          passthru, fl, emit_pt, endf, close, fin, wrap, restart, out_free;
    logic [SB-1:0] s, min_n, max_n, mid_n, val1;
    logic [wd_pkg::SUM_W-1:0] sum_n;
    logic [SW-1:0] cnt_n, end_a, end_b, half;
    logic [DW-1:0] op1, rem_a, rem_b;
    logic          div_busy;
    logic [wd_pkg::SUM_W-1:0] div_quo;
    logic [SW-1:0] div_rem;

    always_comb begin
        if (r_src == '0) begin
            s_eff = SW'(1);
        end else if (r_src > SW'(wd_pkg::MAX_SRC)) begin
            s_eff = SW'(wd_pkg::MAX_SRC);
        end else begin
            s_eff = r_src;
        end
        if (r_dst < DW'(2)) begin
            d_eff = DW'(2);
        end else if (r_dst > DW'(wd_pkg::MAX_DST)) begin
            d_eff = DW'(wd_pkg::MAX_DST);
        end else begin
            d_eff = r_dst;
        end
    end

    assign sm1      = AW'(s_eff - SW'(1));
    assign dm1      = RW'(d_eff - DW'(1));
    assign passthru = s_eff <= SW'(d_eff);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        fl      = i_item.mode;
        s       = i_item.sample;
        p       = r_spos[AW-1:0];
        sum_n   = r_sum + wd_pkg::SUM_W'(s);
        cnt_n   = r_cnt + SW'(1);
        min_n   = (s < r_min) ? s : r_min;
        max_n   = (s > r_max) ? s : r_max;
        mid_n   = (p == r_mid_pos) ? s : r_mid_s;
        close   = p >= r_end;
        op1     = r_opos + DW'(1);
        fin     = (op1 >= DW'(dm1)) || (p >= sm1);
        emit_pt = fl || (r_spos < s_eff);
        endf    = r_opos >= DW'(dm1);

        end_a = SW'(p) + SW'(r_q);
        rem_a = DW'(r_rem) + DW'(r_r);
        wrap  = rem_a >= DW'(dm1);
        rem_b = wrap ? rem_a - DW'(dm1) : rem_a;
        end_b = end_a + SW'(wrap);
        end_c = (end_b > SW'(sm1)) ? sm1 : end_b[AW-1:0];
        half  = (SW'(end_c) - SW'(p) + SW'(1)) >> 1;
        mid_c = p + half[AW-1:0];

        if (r_mode == wd_pkg::MODE_PEAK) begin
            val1 = r_opos[0] ? max_n : min_n;
        end else begin
            val1 = mid_n;
        end

        if (passthru) begin
            direct.point_value = fl ? r_last : s;
            direct.frame_end   = endf;
        end else begin
            direct.point_value = val1;
            direct.frame_end   = 1'b0;
        end
        direct.point_index = r_opos[IW-1:0];

        n_spos = r_spos;  n_opos = r_opos;  n_end = r_end;  n_mid_pos = r_mid_pos;
        n_rem  = r_rem;   n_sum  = r_sum;   n_cnt = r_cnt;  n_min = r_min;
        n_max  = r_max;   n_mid_s = r_mid_s; n_last = r_last;
        n_avg_idx = r_avg_idx;
        n_pend    = r_pend;
        restart   = i_cmd.load_qr;

        if (i_cmd.step) begin
            if (passthru) begin
                if (emit_pt) begin
                    if (!fl) begin
                        n_last = s;
                        n_spos = r_spos + SW'(1);
                    end
                    if (endf) begin
                        restart = 1'b1;
                    end else begin
                        n_opos = op1;
                    end
                end
            end else if (!fl) begin
                n_last  = s;
                n_sum   = sum_n;
                n_cnt   = cnt_n;
                n_min   = min_n;
                n_max   = max_n;
                n_mid_s = mid_n;
                n_spos  = SW'(p) + SW'(1);
                if (close) begin
                    n_avg_idx          = r_opos[IW-1:0];
                    n_pend.point_value = s;
                    n_pend.point_index = IW'(dm1);
                    n_pend.frame_end   = 1'b1;
                    if (fin) begin
                        restart = 1'b1;
                    end else begin
                        n_opos    = op1;
                        n_end     = end_c;
                        n_rem     = RW'(rem_b);
                        n_mid_pos = mid_c;
                        n_sum     = wd_pkg::SUM_W'(s);
                        n_cnt     = SW'(1);
                        n_min     = s;
                        n_max     = s;
                        n_mid_s   = s;
                    end
                end
            end
        end

        qv = i_cmd.load_qr ? div_quo[AW-1:0] : r_q;
        rv = i_cmd.load_qr ? div_rem[RW-1:0] : r_r;
        if (restart) begin
            n_spos    = '0;
            n_opos    = '0;
            n_end     = qv;
            n_rem     = rv;
            n_mid_pos = AW'((SW'(qv) + SW'(1)) >> 1);
            n_sum     = '0;
            n_cnt     = '0;
            n_min     = '1;
            n_max     = '0;
            n_mid_s   = '0;
        end
    end

    wd_divider #(
        .DIVIDEND_W(wd_pkg::SUM_W),
        .DIVISOR_W (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_cfg || i_cmd.div_avg),
        .i_dividend (i_cmd.div_cfg ? wd_pkg::SUM_W'(sm1) : sum_n),
        .i_divisor  (i_cmd.div_cfg ? SW'(dm1) : cnt_n),
        .o_busy     (div_busy),
        .o_quotient (div_quo),
        .o_remainder(div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src       <= SW'(wd_pkg::MAX_SRC);
            r_dst       <= DW'(wd_pkg::MAX_DST);
            r_mode      <= wd_pkg::MODE_MID;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wd_pkg::CFG_SRC_COUNT:   r_src  <= i_cfg_data;
                    wd_pkg::CFG_DST_COUNT:   r_dst  <= i_cfg_data[DW-1:0];
                    wd_pkg::CFG_REDUCE_MODE: r_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            r_last <= n_last;
            if (i_cmd.load_direct || i_cmd.load_div || i_cmd.load_pend) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_qr) begin
            r_q <= qv;
            r_r <= rv;
        end
        r_spos    <= n_spos;
        r_opos    <= n_opos;
        r_end     <= n_end;
        r_mid_pos <= n_mid_pos;
        r_rem     <= n_rem;
        r_sum     <= n_sum;
        r_cnt     <= n_cnt;
        r_min     <= n_min;
        r_max     <= n_max;
        r_mid_s   <= n_mid_s;
        r_avg_idx <= n_avg_idx;
        r_pend    <= n_pend;
        if (i_cmd.load_direct) begin
            r_out <= direct;
        end else if (i_cmd.load_div) begin
            r_out.point_value <= div_quo[SB-1:0];
            r_out.point_index <= r_avg_idx;
            r_out.frame_end   <= 1'b0;
        end else if (i_cmd.load_pend) begin
            r_out <= r_pend;
        end
    end

    assign o_status.cfg_write = i_cfg_we && (i_cfg_idx == wd_pkg::CFG_SRC_COUNT ||
                                             i_cfg_idx == wd_pkg::CFG_DST_COUNT ||
                                             i_cfg_idx == wd_pkg::CFG_REDUCE_MODE);
    assign o_status.out_free  = out_free;
    assign o_status.emit      = passthru ? emit_pt : (!fl && close);
    assign o_status.close     = !passthru && !fl && close;
    assign o_status.two       = !passthru && !fl && close && fin;
    assign o_status.avg       = r_mode == wd_pkg::MODE_AVG;
    assign o_status.div_busy  = div_busy;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

// ----- rtl/core/wd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wd_ctrl
// Sequencer: bin step setup, item acceptance, average divide, second point.
// ----------------------------------------------------------------------------
module wd_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire wd_pkg::t_dp_status i_status,
    output      wd_pkg::t_dp_cmd    o_cmd
);
    typedef enum logic [2:0] {
        ST_CFG_START,
        ST_CFG_WAIT,
        ST_IDLE,
        ST_AVG_WAIT,
        ST_PEND
    } t_state;

    t_state r_state, n_state;
    logic   r_two, n_two;
    logic   accept;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_two   = r_two;
        accept  = 1'b0;
        case (r_state)
            ST_CFG_START: begin
                o_cmd.div_cfg = 1'b1;
                n_state       = ST_CFG_WAIT;
            end
            ST_CFG_WAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.load_qr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_IDLE: begin
                accept = i_in_valid && i_status.out_free;
                if (accept) begin
                    o_cmd.step = 1'b1;
                    n_two      = i_status.two;
                    if (i_status.close && i_status.avg) begin
                        o_cmd.div_avg = 1'b1;
                        n_state       = ST_AVG_WAIT;
                    end else if (i_status.emit) begin
                        o_cmd.load_direct = 1'b1;
                        if (i_status.two) begin
                            n_state = ST_PEND;
                        end
                    end
                end
            end
            ST_AVG_WAIT: begin
                if (!i_status.div_busy && i_status.out_free) begin
                    o_cmd.load_div = 1'b1;
                    n_state        = r_two ? ST_PEND : ST_IDLE;
                end
            end
            ST_PEND: begin
                if (i_status.out_free) begin
                    o_cmd.load_pend = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_CFG_START;
        endcase
        if (i_status.cfg_write) begin
            n_state = ST_CFG_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CFG_START;
            r_two   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_two   <= n_two;
        end
    end

    assign o_in_stall = !(r_state == ST_IDLE && i_status.out_free);
endmodule
`default_nettype wire

// ----- rtl/core/waveform_decimator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_decimator
// Reduces a frame of samples to display points by middle sample, average or
// alternating min/max peak detect.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is free, in pass-through
// and for samples that do not close a bin. A closing sample that also ends
// the frame adds a second point, loaded before the next item is taken. In
// average mode a closing sample also waits for the 24-step shared restoring
// divider that forms the bin mean. After reset and after each configuration
// write the input stalls while the same divider forms the bin step and
// remainder. Results sit in one output register; a new item is taken only
// while that register is empty or its point transfers in the same cycle, so
// a stalled output stalls the input.
module waveform_decimator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [wd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [wd_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                         i_in_valid,
    output      logic                         o_in_stall,
    input  wire wd_pkg::t_in_item             i_in_data,
    output      logic                         o_out_valid,
    input  wire logic                         i_out_stall,
    output      wd_pkg::t_out_item            o_out_data
);
    wd_pkg::t_dp_cmd    cmd;
    wd_pkg::t_dp_status status;

    wd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    wd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );
endmodule
`default_nettype wire
